// ----- hdl/ple_pkg.sv -----
package ple_pkg;

  // List geometry.
  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  // Width in which positions and the fill count are compared.
  localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;
  localparam int LEN_W = 5;
  localparam int LEN_EXT_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  // Command codes.
  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_READ    = 2'd1;
  localparam logic [1:0] CMD_REMOVE  = 2'd2;
  localparam logic [1:0] CMD_REVERSE = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  // What every cell of the row does in a cycle.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SHIFT_UP,
    CELL_SHIFT_DOWN,
    CELL_LOAD_KEY,
    CELL_SORT
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic               parity;
    logic [CMP_W-1:0]   pos;
    logic [CNT_W-1:0]   count;
  } cell_ctrl_t;

  // Fill count as shown on the length field, modulo 32.
  function automatic logic [LEN_W-1:0] len_of(input logic [CNT_W-1:0] c);
    logic [LEN_EXT_W-1:0] wide;
    wide = LEN_EXT_W'(c);
    return wide[LEN_W-1:0];
  endfunction

endpackage

// ----- hdl/ple_if.sv -----
interface ple_in_if (input logic clk);
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic signed [31:0] value;
  logic [3:0]         position;

  modport source (output valid, output command, output value, output position, input ready);
  modport sink (input valid, input command, input value, input position, output ready);
endinterface

interface ple_out_if (input logic clk);
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] read_value;
  logic [4:0]         length;

  modport source (output valid, output status, output read_value, output length, input ready);
  modport sink (input valid, input status, input read_value, input length, output ready);
endinterface

// ----- hdl/positional_list_engine.sv -----
// Positional list engine: an ordered list of up to DEPTH signed 32-bit
// values held in a row of cells, one entry per cell, plus a fill count.
// Each command word produces exactly one result word. Insert-front, read-at
// and remove-at complete in the cycle the command word is accepted, so they
// run at one word per cycle as long as results are taken; insert and remove
// move every affected cell one place toward its neighbor at once, and a read
// selects one cell. Reverse first tags every cell with its mirrored position,
// then DEPTH odd-even exchange steps between neighboring cells put the
// entries in their new order; no command word is taken meanwhile. A result
// word waits in an output register, and the next command word is taken
// while it is being taken. Entries past the fill count are never read, so
// the cells need no reset.
module positional_list_engine (
  input  logic      clk,
  input  logic      rst,
  ple_in_if.sink    cmd,
  ple_out_if.source res
);

  typedef enum logic {S_IDLE, S_REV} state_t;

  state_t                    state;
  logic [ple_pkg::CNT_W-1:0] fill_count;
  logic [ple_pkg::CNT_W-1:0] phase;
  logic                      out_valid;
  logic                      out_valid_next;
  logic [1:0]                out_status;
  logic [31:0]               out_read_value;
  logic [4:0]                out_length;

  ple_pkg::cell_ctrl_t       ctrl;
  logic [31:0]               cell_data [ple_pkg::DEPTH];
  logic [ple_pkg::IDX_W-1:0] cell_key [ple_pkg::DEPTH];

  logic                      accept;
  logic [ple_pkg::CMP_W-1:0] pos_ext;
  logic [ple_pkg::CMP_W-1:0] count_ext;
  logic                      is_full;
  logic                      is_empty;
  logic                      pos_bad;
  logic                      rev_last;

  assign cmd.ready      = (state == S_IDLE) && (!out_valid || res.ready);
  assign accept         = cmd.valid && cmd.ready;
  assign res.valid      = out_valid;
  assign res.status     = out_status;
  assign res.read_value = out_read_value;
  assign res.length     = out_length;

  assign pos_ext   = ple_pkg::CMP_W'(cmd.position);
  assign count_ext = ple_pkg::CMP_W'(fill_count);
  assign is_full   = (fill_count == ple_pkg::CNT_W'(ple_pkg::DEPTH));
  assign is_empty  = (fill_count == '0);
  assign pos_bad   = (pos_ext >= count_ext);
  assign rev_last  = (phase == ple_pkg::CNT_W'(ple_pkg::DEPTH - 1));

  // A result word stays until it is taken. Every command other than reverse
  // loads a new one at once; reverse loads it at the end of its last step.
  assign out_valid_next = (out_valid && !res.ready)
                       || (accept && (cmd.command != ple_pkg::CMD_REVERSE))
                       || ((state == S_REV) && rev_last);

  // Row control: what every cell does this cycle.
  always_comb begin
    ctrl.op     = ple_pkg::CELL_HOLD;
    ctrl.parity = phase[0];
    ctrl.pos    = pos_ext;
    ctrl.count  = fill_count;
    if (state == S_REV) begin
      ctrl.op = ple_pkg::CELL_SORT;
    end else if (accept) begin
      unique case (cmd.command)
        ple_pkg::CMD_INSERT: begin
          if (!is_full) begin
            ctrl.op = ple_pkg::CELL_SHIFT_UP;
          end
        end
        ple_pkg::CMD_REMOVE: begin
          if (!is_empty && !pos_bad) begin
            ctrl.op = ple_pkg::CELL_SHIFT_DOWN;
          end
        end
        ple_pkg::CMD_REVERSE: begin
          ctrl.op = ple_pkg::CELL_LOAD_KEY;
        end
        default: begin
        end
      endcase
    end
  end

  // The row of cells. The front cell takes the inserted value from its left;
  // the ends see their own key so that no exchange happens across them.
  for (genvar i = 0; i < ple_pkg::DEPTH; i++) begin : g_cell
    logic [31:0]               l_data;
    logic [ple_pkg::IDX_W-1:0] l_key;
    logic [31:0]               r_data;
    logic [ple_pkg::IDX_W-1:0] r_key;

    if (i == 0) begin : g_front
      assign l_data = cmd.value;
      assign l_key  = cell_key[i];
    end else begin : g_inner_l
      assign l_data = cell_data[i-1];
      assign l_key  = cell_key[i-1];
    end

    if (i == ple_pkg::DEPTH - 1) begin : g_back
      assign r_data = cell_data[i];
      assign r_key  = cell_key[i];
    end else begin : g_inner_r
      assign r_data = cell_data[i+1];
      assign r_key  = cell_key[i+1];
    end

    ple_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .index      (ple_pkg::IDX_W'(i)),
      .left_data  (l_data),
      .left_key   (l_key),
      .right_data (r_data),
      .right_key  (r_key),
      .data       (cell_data[i]),
      .key        (cell_key[i])
    );
  end

  // Sequencer, fill count and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_count <= '0;
      phase      <= '0;
      out_valid  <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (cmd.command)
              ple_pkg::CMD_INSERT: begin
                out_read_value <= '0;
                if (is_full) begin
                  out_status <= ple_pkg::ST_FULL;
                  out_length <= ple_pkg::len_of(fill_count);
                end else begin
                  out_status <= ple_pkg::ST_OK;
                  fill_count <= fill_count + ple_pkg::CNT_W'(1);
                  out_length <= ple_pkg::len_of(fill_count + ple_pkg::CNT_W'(1));
                end
              end
              ple_pkg::CMD_READ: begin
                out_length <= ple_pkg::len_of(fill_count);
                if (pos_bad) begin
                  out_status     <= ple_pkg::ST_BADPOS;
                  out_read_value <= '0;
                end else begin
                  out_status     <= ple_pkg::ST_OK;
                  out_read_value <= cell_data[pos_ext[ple_pkg::IDX_W-1:0]];
                end
              end
              ple_pkg::CMD_REMOVE: begin
                out_read_value <= '0;
                if (is_empty) begin
                  out_status <= ple_pkg::ST_EMPTY;
                  out_length <= ple_pkg::len_of(fill_count);
                end else if (pos_bad) begin
                  out_status <= ple_pkg::ST_BADPOS;
                  out_length <= ple_pkg::len_of(fill_count);
                end else begin
                  out_status <= ple_pkg::ST_OK;
                  fill_count <= fill_count - ple_pkg::CNT_W'(1);
                  out_length <= ple_pkg::len_of(fill_count - ple_pkg::CNT_W'(1));
                end
              end
              ple_pkg::CMD_REVERSE: begin
                state <= S_REV;
                phase <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_REV: begin
          phase <= phase + ple_pkg::CNT_W'(1);
          if (rev_last) begin
            state          <= S_IDLE;
            out_status     <= ple_pkg::ST_OK;
            out_read_value <= '0;
            out_length     <= ple_pkg::len_of(fill_count);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    fill_count <= ple_pkg::CNT_W'(ple_pkg::DEPTH))
    else $error("fill count above list depth");

  a_no_accept_in_reverse: assert property (@(posedge clk) disable iff (rst)
    (state == S_REV) |-> !cmd.ready)
    else $error("command taken while reversing");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.command == ple_pkg::CMD_INSERT && !is_full)
      |=> (fill_count == $past(fill_count) + ple_pkg::CNT_W'(1)))
    else $error("insert did not grow the list");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.command != ple_pkg::CMD_REVERSE) |=> res.valid)
    else $error("no result after a command");

  a_reverse_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_REV) |=> (fill_count == $past(fill_count)))
    else $error("fill count changed during reverse");
`endif

endmodule

// ----- hdl/ple_cell.sv -----
// One list entry. It shifts toward either neighbor, or takes part in an
// odd-even exchange step keyed by its target position.
module ple_cell (
  input  logic                          clk,
  input  ple_pkg::cell_ctrl_t           ctrl,
  input  logic [ple_pkg::IDX_W-1:0]     index,
  input  logic [31:0]                   left_data,
  input  logic [ple_pkg::IDX_W-1:0]     left_key,
  input  logic [31:0]                   right_data,
  input  logic [ple_pkg::IDX_W-1:0]     right_key,
  output logic [31:0]                   data,
  output logic [ple_pkg::IDX_W-1:0]     key
);

  logic [ple_pkg::CNT_W-1:0] index_cnt;
  logic [ple_pkg::CNT_W-1:0] mirror;
  logic [ple_pkg::IDX_W-1:0] key_init;
  logic                      is_left;

  assign index_cnt = ple_pkg::CNT_W'(index);
  assign mirror    = ctrl.count - ple_pkg::CNT_W'(1) - index_cnt;
  // Entries in use get their mirrored place; the rest keep their own, which
  // is larger than any mirrored place, so they never move.
  assign key_init  = (index_cnt < ctrl.count) ? mirror[ple_pkg::IDX_W-1:0] : index;
  assign is_left   = (index[0] == ctrl.parity);

  always_ff @(posedge clk) begin
    case (ctrl.op)
      ple_pkg::CELL_SHIFT_UP: begin
        data <= left_data;
      end
      ple_pkg::CELL_SHIFT_DOWN: begin
        if (ple_pkg::CMP_W'(index) >= ctrl.pos) begin
          data <= right_data;
        end
      end
      ple_pkg::CELL_LOAD_KEY: begin
        key <= key_init;
      end
      ple_pkg::CELL_SORT: begin
        if (is_left) begin
          if (key > right_key) begin
            data <= right_data;
            key  <= right_key;
          end
        end else begin
          if (left_key > key) begin
            data <= left_data;
            key  <= left_key;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule
